// File: src/fsoe_pkg.sv
package fsoe_pkg;

    localparam logic [3:0] ACT_WRITE_ACQ = 4'd0;
    localparam logic [3:0] ACT_PUBLISH   = 4'd1;
    localparam logic [3:0] ACT_CANCEL    = 4'd2;
    localparam logic [3:0] ACT_DISP_ACQ  = 4'd3;
    localparam logic [3:0] ACT_DISP_REL  = 4'd4;
    localparam logic [3:0] ACT_LAT_ACQ   = 4'd5;
    localparam logic [3:0] ACT_LAT_REL   = 4'd6;
    localparam logic [3:0] ACT_MOT_ACQ   = 4'd7;
    localparam logic [3:0] ACT_MOT_REL   = 4'd8;

    localparam logic [1:0] CFG_DISPLAY_EN = 2'd0;
    localparam logic [1:0] CFG_LATEST_EN  = 2'd1;
    localparam logic [1:0] CFG_MOTION_EN  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_APPLY
    } t_state;

    typedef struct packed {
        logic load;
        logic scan_step;
        logic apply;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_req;
        logic scan_last;
        logic out_free;
    } t_dp_sts;

endpackage

// File: src/frame_slot_ownership_engine_top.sv
// Frame slot ownership engine.
// Requests enter on i_valid/o_ready as action, slot and frame tag; each accepted
// word yields exactly one result word on o_valid/i_ready carrying ok, the granted
// slot, its frame tag and the running superseded count.
// The three consumer enables are written on the configuration channel
// (i_cfg_valid/o_cfg_ready, index 0 display, 1 latest, 2 motion); it is always
// ready and should only be written while no request is in flight.
// One request is handled at a time. Publish, cancel, releases and unknown
// actions pass from acceptance through ST_CHECK to ST_APPLY, where the result
// is loaded into the output register. Acquires step through ST_SCAN between
// them, walking the slot ring one slot per cycle through the shared compare unit.
// The next request is accepted in the cycle after its predecessor's result is
// loaded into the output register.
// When the receiver stalls, the result is held in the output register and a
// further request is still accepted and worked; it waits for its final update
// until the pending result is taken.
// Synchronous active-low reset empties every slot, clears all claims, the
// write pointer, the newest-frame record, the count and the enables.
module frame_slot_ownership_engine_top #(
    parameter int SLOTS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [3:0]  i_action,
    input  logic [3:0]  i_slot,
    input  logic [31:0] i_frame_tag,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic        i_cfg_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_ok,
    output logic [3:0]  o_slot_out,
    output logic [31:0] o_tag_out,
    output logic [31:0] o_superseded_count
);
    import fsoe_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    fsoe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    fsoe_dpath #(
        .SLOTS (SLOTS)
    ) u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_action           (i_action),
        .i_slot             (i_slot),
        .i_frame_tag        (i_frame_tag),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_ok               (o_ok),
        .o_slot_out         (o_slot_out),
        .o_tag_out          (o_tag_out),
        .o_superseded_count (o_superseded_count)
    );

endmodule

// File: src/fsoe_ctrl.sv
module fsoe_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    output fsoe_pkg::t_dp_cmd o_cmd,
    input  fsoe_pkg::t_dp_sts i_sts
);
    import fsoe_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_ready         = 1'b0;
        o_cmd.load      = 1'b0;
        o_cmd.scan_step = 1'b0;
        o_cmd.apply     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_state = i_sts.scan_req ? ST_SCAN : ST_APPLY;
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = ST_APPLY;
                end
            end
            ST_APPLY: begin
                if (i_sts.out_free) begin
                    o_cmd.apply = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// File: src/fsoe_dpath.sv
module fsoe_dpath #(
    parameter int SLOTS = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fsoe_pkg::t_dp_cmd i_cmd,
    output fsoe_pkg::t_dp_sts o_sts,
    input  logic [3:0]        i_action,
    input  logic [3:0]        i_slot,
    input  logic [31:0]       i_frame_tag,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic              i_cfg_data,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_ok,
    output logic [3:0]        o_slot_out,
    output logic [31:0]       o_tag_out,
    output logic [31:0]       o_superseded_count
);
    import fsoe_pkg::*;

    localparam int SW = $clog2(SLOTS);

    logic r_display_en;
    logic r_latest_en;
    logic r_motion_en;

    logic [3:0]  r_action;
    logic [3:0]  r_slot;
    logic [31:0] r_frame_tag;

    logic [SLOTS-1:0] r_writing,   n_writing;
    logic [SLOTS-1:0] r_published, n_published;
    logic [SLOTS-1:0] r_dpend,     n_dpend;
    logic [SLOTS-1:0] r_dheld,     n_dheld;
    logic [SLOTS-1:0] r_lpend,     n_lpend;
    logic [SLOTS-1:0] r_lheld,     n_lheld;
    logic [SLOTS-1:0] r_mpend,     n_mpend;
    logic [SLOTS-1:0] r_mheld,     n_mheld;
    logic [31:0]      r_tag [SLOTS];
    logic [SW-1:0]    r_next_write,  n_next_write;
    logic             r_newest_valid, n_newest_valid;
    logic [SW-1:0]    r_newest_slot,  n_newest_slot;
    logic [31:0]      r_drop,         n_drop;

    logic [SW-1:0] r_idx;
    logic [SW-1:0] r_cnt;
    logic          r_found;
    logic [SW-1:0] r_best;
    logic [31:0]   r_best_tag;

    logic        r_out_valid;
    logic        r_ok;
    logic [3:0]  r_slot_out;
    logic [31:0] r_tag_out;
    logic [31:0] r_cnt_out;

    logic          tag_we;
    logic          n_ok;
    logic [3:0]    n_slot_out;
    logic [31:0]   n_tag_out;
    logic          qualify;
    logic [31:0]   tag_k;
    logic [SW-1:0] s;
    logic [SW-1:0] ns;
    logic          in_range;
    logic [SW-1:0] idx_inc;

    assign s        = r_slot[SW-1:0];
    assign ns       = r_newest_slot;
    assign in_range = {1'b0, r_slot} < 5'(SLOTS);
    assign tag_k    = r_tag[r_idx];
    assign idx_inc  = (r_idx == SW'(SLOTS - 1)) ? '0 : r_idx + 1'b1;

    assign o_cfg_ready = 1'b1;

    assign o_sts.scan_req  = (r_action == ACT_WRITE_ACQ) || (r_action == ACT_DISP_ACQ) ||
                             (r_action == ACT_LAT_ACQ) || (r_action == ACT_MOT_ACQ);
    assign o_sts.scan_last = (r_cnt == SW'(SLOTS - 1));
    assign o_sts.out_free  = !r_out_valid || i_ready;

    always_comb begin
        qualify = 1'b0;
        unique case (r_action)
            ACT_WRITE_ACQ: begin
                qualify = !r_found && !r_writing[r_idx] && !r_published[r_idx];
            end
            ACT_DISP_ACQ: begin
                qualify = r_published[r_idx] && r_dpend[r_idx] && !r_dheld[r_idx] &&
                          (tag_k < r_best_tag);
            end
            ACT_MOT_ACQ: begin
                qualify = r_published[r_idx] && r_mpend[r_idx] && !r_mheld[r_idx] &&
                          (tag_k < r_best_tag);
            end
            ACT_LAT_ACQ: begin
                qualify = r_newest_valid && (r_idx == r_newest_slot) &&
                          r_published[r_idx] && r_lpend[r_idx] && !r_lheld[r_idx];
            end
            default: begin
                qualify = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_writing      = r_writing;
        n_published    = r_published;
        n_dpend        = r_dpend;
        n_dheld        = r_dheld;
        n_lpend        = r_lpend;
        n_lheld        = r_lheld;
        n_mpend        = r_mpend;
        n_mheld        = r_mheld;
        n_next_write   = r_next_write;
        n_newest_valid = r_newest_valid;
        n_newest_slot  = r_newest_slot;
        n_drop         = r_drop;
        tag_we         = 1'b0;
        n_ok           = 1'b0;
        n_slot_out     = '0;
        n_tag_out      = '0;
        unique case (r_action)
            ACT_WRITE_ACQ: begin
                if (r_found) begin
                    n_writing[r_best] = 1'b1;
                    n_next_write      = (r_best == SW'(SLOTS - 1)) ? '0 : r_best + 1'b1;
                    n_ok              = 1'b1;
                    n_slot_out        = 4'(r_best);
                end
            end
            ACT_PUBLISH: begin
                if (in_range && r_writing[s]) begin
                    tag_we     = 1'b1;
                    n_dpend[s] = r_display_en;
                    n_dheld[s] = 1'b0;
                    if (r_latest_en) begin
                        if (r_newest_valid && (ns != s) && r_lpend[ns] && !r_lheld[ns]) begin
                            n_lpend[ns] = 1'b0;
                            n_drop      = r_drop + 32'd1;
                            if (!r_dpend[ns] && !r_mpend[ns]) begin
                                n_writing[ns]   = 1'b0;
                                n_published[ns] = 1'b0;
                            end
                        end
                        n_lpend[s]     = 1'b1;
                        n_lheld[s]     = 1'b0;
                        n_newest_valid = 1'b1;
                        n_newest_slot  = s;
                    end else begin
                        n_lpend[s] = 1'b0;
                        n_lheld[s] = 1'b0;
                    end
                    n_mpend[s]     = r_motion_en;
                    n_mheld[s]     = 1'b0;
                    n_writing[s]   = 1'b0;
                    n_published[s] = 1'b1;
                end
            end
            ACT_CANCEL: begin
                if (in_range && r_writing[s]) begin
                    n_writing[s] = 1'b0;
                end
            end
            ACT_DISP_ACQ: begin
                if (r_found) begin
                    n_dheld[r_best] = 1'b1;
                    n_ok            = 1'b1;
                    n_slot_out      = 4'(r_best);
                    n_tag_out       = r_best_tag;
                end
            end
            ACT_LAT_ACQ: begin
                if (r_found) begin
                    n_lheld[r_best] = 1'b1;
                    n_ok            = 1'b1;
                    n_slot_out      = 4'(r_best);
                    n_tag_out       = r_best_tag;
                end
            end
            ACT_MOT_ACQ: begin
                if (r_found) begin
                    n_mheld[r_best] = 1'b1;
                    n_ok            = 1'b1;
                    n_slot_out      = 4'(r_best);
                    n_tag_out       = r_best_tag;
                end
            end
            ACT_DISP_REL: begin
                if (in_range && r_dheld[s]) begin
                    n_dheld[s] = 1'b0;
                    n_dpend[s] = 1'b0;
                    if (!r_lpend[s] && !r_mpend[s]) begin
                        n_writing[s]   = 1'b0;
                        n_published[s] = 1'b0;
                    end
                end
            end
            ACT_LAT_REL: begin
                if (in_range && r_lheld[s]) begin
                    n_lheld[s] = 1'b0;
                    n_lpend[s] = 1'b0;
                    if (r_newest_valid && (ns == s)) begin
                        n_newest_valid = 1'b0;
                    end
                    if (!r_dpend[s] && !r_mpend[s]) begin
                        n_writing[s]   = 1'b0;
                        n_published[s] = 1'b0;
                    end
                end
            end
            ACT_MOT_REL: begin
                if (in_range && r_mheld[s]) begin
                    n_mheld[s] = 1'b0;
                    n_mpend[s] = 1'b0;
                    if (!r_dpend[s] && !r_lpend[s]) begin
                        n_writing[s]   = 1'b0;
                        n_published[s] = 1'b0;
                    end
                end
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_display_en   <= 1'b0;
            r_latest_en    <= 1'b0;
            r_motion_en    <= 1'b0;
            r_writing      <= '0;
            r_published    <= '0;
            r_dpend        <= '0;
            r_dheld        <= '0;
            r_lpend        <= '0;
            r_lheld        <= '0;
            r_mpend        <= '0;
            r_mheld        <= '0;
            r_next_write   <= '0;
            r_newest_valid <= 1'b0;
            r_newest_slot  <= '0;
            r_drop         <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_DISPLAY_EN: r_display_en <= i_cfg_data;
                    CFG_LATEST_EN:  r_latest_en  <= i_cfg_data;
                    CFG_MOTION_EN:  r_motion_en  <= i_cfg_data;
                    default: begin
                        r_display_en <= r_display_en;
                    end
                endcase
            end
            if (i_cmd.apply) begin
                r_writing      <= n_writing;
                r_published    <= n_published;
                r_dpend        <= n_dpend;
                r_dheld        <= n_dheld;
                r_lpend        <= n_lpend;
                r_lheld        <= n_lheld;
                r_mpend        <= n_mpend;
                r_mheld        <= n_mheld;
                r_next_write   <= n_next_write;
                r_newest_valid <= n_newest_valid;
                r_newest_slot  <= n_newest_slot;
                r_drop         <= n_drop;
                r_out_valid    <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action    <= i_action;
            r_slot      <= i_slot;
            r_frame_tag <= i_frame_tag;
            r_idx       <= (i_action == ACT_WRITE_ACQ) ? r_next_write : '0;
            r_cnt       <= '0;
            r_found     <= 1'b0;
            r_best      <= '0;
            r_best_tag  <= '1;
        end else if (i_cmd.scan_step) begin
            r_idx <= idx_inc;
            r_cnt <= r_cnt + 1'b1;
            if (qualify) begin
                r_found    <= 1'b1;
                r_best     <= r_idx;
                r_best_tag <= tag_k;
            end
        end
        if (i_cmd.apply) begin
            r_ok       <= n_ok;
            r_slot_out <= n_slot_out;
            r_tag_out  <= n_tag_out;
            r_cnt_out  <= n_drop;
        end
        if (tag_we && i_cmd.apply) begin
            r_tag[s] <= r_frame_tag;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_ok               = r_ok;
    assign o_slot_out         = r_slot_out;
    assign o_tag_out          = r_tag_out;
    assign o_superseded_count = r_cnt_out;

    a_phase_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_writing & r_published) == '0)
        else $error("slot both writing and published");

    a_held_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_dheld & ~r_dpend) | (r_lheld & ~r_lpend) | (r_mheld & ~r_mpend)) == '0)
        else $error("claim held without pending mark");

    a_pending_published: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_dpend | r_lpend | r_mpend) & ~r_published) == '0)
        else $error("pending mark on a slot that is not published");

    a_apply_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.apply |-> (!r_out_valid || i_ready))
        else $error("result overwrites an untaken word");

    a_drop_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_drop != $past(r_drop)) |-> (r_drop == $past(r_drop) + 32'd1))
        else $error("drop count moved by more than one");

endmodule
